### rtl/core/damt_pkg.sv
// Shared types, constants and codes for the device alias match table.
`default_nettype none

package damt_pkg;

  // Table geometry and the free-slot marker
  localparam int unsigned USER_SLOTS  = 8;
  localparam int unsigned FIXED_SLOTS = 4;
  localparam int unsigned FIXED_REGS  = 4;
  localparam int unsigned IDX_W       = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;

  localparam int unsigned ALIAS_W  = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ALIAS_W-1:0] UNUSED_CODE = 8'hFF;
  localparam logic [ALIAS_W-1:0] FIXED_RESET = 8'hFF;

  // Request codes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_NO_MATCH = 2'd2
  } status_e;

  // One result; first field in the highest bits
  typedef struct packed {
    logic              filter_enable;
    logic              filter_update;
    logic [SLOT_W-1:0] slot;
    logic              accepted;
    status_e           status;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // take the accepted request and restart the scan
    logic step;  // examine one user slot
    logic emit;  // move the finished result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;  // the slot under examination ends the scan
  } stat_t;

endpackage

`default_nettype wire

### rtl/core/device_alias_match_table.sv
// The scan examines one user slot per cycle and stops at the first deciding slot;
// the result then passes through a holding register into the output register.
// One request at a time: a new request is taken only after the previous result has moved on;
// the next request is taken while the previous result waits in the output register.
// Reset (asynchronous, active low): every user slot reads as the unused code,
// predefined aliases return to 255, no result is pending.
`default_nettype none

module device_alias_match_table
  import damt_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // Request stream
  input  wire                  s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire  [15:0]          s_axis_tdata,   // [1:0] operation, [9:2] alias_req
  // Result stream
  output logic                 m_axis_tvalid,
  input  wire                  m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [1:0] status, [2] accepted, [5:3] slot,
                                               // [6] filter_update, [7] filter_enable
  // Configuration writes
  input  wire                  cfg_we_i,
  input  wire  [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [ALIAS_W-1:0]   cfg_wdata_i
);

  cmd_t    cmd;
  stat_t   stat;
  result_t result;

  damt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  damt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (s_axis_tdata[1:0]),
    .alias_i     (s_axis_tdata[9:2]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (result)
  );

  assign m_axis_tdata = result;

endmodule

`default_nettype wire

### rtl/core/damt_ctrl.sv
// Sequencer for the alias table: accept, scan, hold and hand over the result.
`default_nettype none

module damt_ctrl
  import damt_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  wire   out_ready_i,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (stat_i.done) begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/damt_datapath.sv
// Alias storage, slot scanner, result formation and output register.
`default_nettype none

module damt_datapath
  import damt_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  [1:0]           op_i,
  input  wire  [ALIAS_W-1:0]   alias_i,
  input  wire                  cfg_we_i,
  input  wire  [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [ALIAS_W-1:0]   cfg_wdata_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  output result_t              out_o
);

  logic [ALIAS_W-1:0] fixed_q [FIXED_REGS];
  logic [ALIAS_W-1:0] table_q [USER_SLOTS];

  logic [1:0]         op_q;
  logic [ALIAS_W-1:0] alias_q;
  logic [IDX_W-1:0]   idx_q;
  logic               hit_q;
  result_t            res_q;
  result_t            out_q;

  logic               fixed_hit;
  logic [ALIAS_W-1:0] entry;
  logic               is_free;
  logic               is_req;
  logic               last;
  logic               done;
  logic               wr_en;
  logic [ALIAS_W-1:0] wr_data;
  result_t            res_d;

  // Compare the request against the predefined aliases in use
  always_comb begin
    fixed_hit = 1'b0;
    for (int i = 0; i < int'(FIXED_SLOTS); i++) begin
      if (fixed_q[i] == alias_i) begin
        fixed_hit = 1'b1;
      end
    end
  end

  // Examine the current user slot
  assign entry   = table_q[idx_q];
  assign is_free = (entry == UNUSED_CODE);
  assign is_req  = (entry == alias_q);
  assign last    = (idx_q == IDX_W'(USER_SLOTS - 1));

  // Decide whether the scan ends here and what it reports
  always_comb begin
    done    = 1'b1;
    wr_en   = 1'b0;
    wr_data = alias_q;
    res_d   = '0;
    case (op_q)
      OP_ADD: begin
        done = is_free || last;
        if (is_free) begin
          wr_en               = 1'b1;
          res_d.slot          = SLOT_W'(idx_q);
          res_d.filter_update = 1'b1;
          res_d.filter_enable = 1'b1;
        end else begin
          res_d.status = STS_FULL;
        end
      end
      OP_REMOVE: begin
        done    = is_req || last;
        wr_data = UNUSED_CODE;
        if (is_req) begin
          wr_en               = 1'b1;
          res_d.slot          = SLOT_W'(idx_q);
          res_d.filter_update = 1'b1;
        end else begin
          res_d.status = STS_NO_MATCH;
        end
      end
      OP_CHECK: begin
        done           = hit_q || is_req || last;
        res_d.accepted = hit_q || is_req;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign stat_o.done = done;

  // Predefined aliases, written from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(FIXED_REGS); i++) begin
        fixed_q[i] <= FIXED_RESET;
      end
    end else if (cfg_we_i) begin
      fixed_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // User table: every slot free after reset, updated when a scan ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(USER_SLOTS); i++) begin
        table_q[i] <= UNUSED_CODE;
      end
    end else if (cmd_i.step && done && wr_en) begin
      table_q[idx_q] <= wr_data;
    end
  end

  // Scan pointer and request hold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
      hit_q <= fixed_hit;
    end else if (cmd_i.step && !done) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      alias_q <= alias_i;
    end
  end

  // Capture the finished result, then move it to the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && done) begin
      res_q <= res_d;
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

### rtl/core/damt_checker.sv
// Port-level checks for the alias table, bound to the top level.
`default_nettype none

module damt_checker
  import damt_pkg::*;
(
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire [15:0]           s_axis_tdata,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [7:0]            m_axis_tdata,
  input wire                  cfg_we_i,
  input wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input wire [ALIAS_W-1:0]    cfg_wdata_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // One request at a time: no transaction right after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while the previous one is still scanning");

  // A filter update only comes with a good status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[1:0] == STS_OK)
    else $error("filter update with error status");

  // Without an update the slot is zero and the filter is not enabled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[5:3] == 3'd0 && !m_axis_tdata[7])
    else $error("slot or enable reported without a filter update");

  // A check hit never changes a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |-> !m_axis_tdata[6] && m_axis_tdata[1:0] == STS_OK)
    else $error("accepted check reported a slot change");

endmodule

bind device_alias_match_table damt_checker u_damt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_we_i      (cfg_we_i),
  .cfg_idx_i     (cfg_idx_i),
  .cfg_wdata_i   (cfg_wdata_i)
);

`default_nettype wire

### bench/device_alias_match_table_checker.sv
// Checker for the device alias match table: tracks the alias slots and compares each result.
`timescale 1ns / 1ps

module device_alias_match_table_checker
  import damt_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_axis_tvalid,
  input  wire                  s_axis_tready,
  input  wire  [15:0]          s_axis_tdata,   // [1:0] operation, [9:2] alias_req
  input  wire                  m_axis_tvalid,
  input  wire                  m_axis_tready,
  input  wire  [7:0]           m_axis_tdata,   // [1:0] status, [2] accepted, [5:3] slot,
                                               // [6] filter_update, [7] filter_enable
  input  wire                  cfg_we_i,
  input  wire  [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [ALIAS_W-1:0]   cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  logic [ALIAS_W-1:0] slot_table [USER_SLOTS];
  logic [ALIAS_W-1:0] fixed_copy [FIXED_REGS];
  result_t            awaited_results [$];
  result_t            seen;
  result_t            wanted;

  // Apply one request to the slot table and form the result it must produce
  function automatic result_t resolve_request(input logic [1:0]         op_bits,
                                              input logic [ALIAS_W-1:0] alias_val);
    result_t res;
    logic    found;
    res   = '0;
    found = 1'b0;
    case (op_bits)
      OP_ADD: begin
        res.status = STS_FULL;
        for (int i = 0; i < USER_SLOTS; i++) begin
          if (!found && slot_table[i] == UNUSED_CODE) begin
            found              = 1'b1;
            slot_table[i]      = alias_val;
            res.status         = STS_OK;
            res.slot           = SLOT_W'(i);
            res.filter_update  = 1'b1;
            res.filter_enable  = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        res.status = STS_NO_MATCH;
        for (int i = 0; i < USER_SLOTS; i++) begin
          if (!found && slot_table[i] == alias_val) begin
            found              = 1'b1;
            slot_table[i]      = UNUSED_CODE;
            res.status         = STS_OK;
            res.slot           = SLOT_W'(i);
            res.filter_update  = 1'b1;
          end
        end
      end
      OP_CHECK: begin
        for (int i = 0; i < FIXED_SLOTS && i < FIXED_REGS; i++)
          if (fixed_copy[i] == alias_val) found = 1'b1;
        for (int i = 0; i < USER_SLOTS; i++)
          if (slot_table[i] == alias_val) found = 1'b1;
        res.accepted = found;
      end
      default: begin
        // unknown operation: leave everything zero
      end
    endcase
    return res;
  endfunction

  // Compare finished results first, then record new configuration and requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < USER_SLOTS; i++) slot_table[i] = UNUSED_CODE;
      for (int i = 0; i < FIXED_REGS; i++) fixed_copy[i] = FIXED_RESET;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = result_t'(m_axis_tdata);
        if (awaited_results.size() == 0) begin
          $error("result %h arrived with no request outstanding", m_axis_tdata);
          fail_count_o++;
        end else begin
          wanted = awaited_results.pop_front();
          if (seen.status !== wanted.status) begin
            $error("status: expected %0d, got %0d", wanted.status, seen.status);
            fail_count_o++;
          end
          if (seen.accepted !== wanted.accepted) begin
            $error("accepted: expected %0d, got %0d", wanted.accepted, seen.accepted);
            fail_count_o++;
          end
          if (seen.slot !== wanted.slot) begin
            $error("slot: expected %0d, got %0d", wanted.slot, seen.slot);
            fail_count_o++;
          end
          if (seen.filter_update !== wanted.filter_update) begin
            $error("filter_update: expected %0d, got %0d",
                   wanted.filter_update, seen.filter_update);
            fail_count_o++;
          end
          if (seen.filter_enable !== wanted.filter_enable) begin
            $error("filter_enable: expected %0d, got %0d",
                   wanted.filter_enable, seen.filter_enable);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) fixed_copy[cfg_idx_i] = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(resolve_request(s_axis_tdata[1:0], s_axis_tdata[9:2]));
      pending_o = awaited_results.size();
    end
  end

endmodule

### bench/device_alias_match_table_tb.sv
// Testbench top for the device alias match table: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module device_alias_match_table_tb;
  import damt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned PHASES       = 4;
  localparam int unsigned DRAIN_CYCLES = 12;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FIXED_ALIAS_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_ALIAS_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_ALIAS_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_ALIAS_3 = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata  = '0;   // [1:0] operation, [9:2] alias_req
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;         // [1:0] status, [2] accepted, [5:3] slot,
                                              // [6] filter_update, [7] filter_enable
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [ALIAS_W-1:0]   cfg_wdata_i   = '0;

  int                   fail_count;
  int                   pending_count;
  int unsigned          cycle_count       = 0;
  logic                 idle_enabled      = 1'b0;
  logic                 long_hold_pending = 1'b0;
  logic [ALIAS_W-1:0]   fixed_now [FIXED_REGS];

  device_alias_match_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  device_alias_match_table_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  // Free-running clock, 4 ns period
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Count cycles and stop a run that hangs
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold_pending) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_pending = 1'b0;
        m_axis_tready     = 1'b1;
      end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Offer one request and hold it until the transaction completes; enter and leave on a falling edge
  task automatic send_request(input logic [1:0] op_bits, input logic [ALIAS_W-1:0] alias_val);
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, alias_val, op_bits};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Drop the request line and wait until every result has been taken
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_fixed(input logic [CFG_IDX_W-1:0] idx, input logic [ALIAS_W-1:0] val);
    cfg_we_i       = 1'b1;
    cfg_idx_i      = idx;
    cfg_wdata_i    = val;
    fixed_now[idx] = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_fixed_aliases(input logic [ALIAS_W-1:0] a0, input logic [ALIAS_W-1:0] a1,
                                   input logic [ALIAS_W-1:0] a2, input logic [ALIAS_W-1:0] a3);
    write_fixed(REG_FIXED_ALIAS_0, a0);
    write_fixed(REG_FIXED_ALIAS_1, a1);
    write_fixed(REG_FIXED_ALIAS_2, a2);
    write_fixed(REG_FIXED_ALIAS_3, a3);
  endtask

  // Pick an alias from the small cluster that adds, removes and checks share
  function automatic logic [ALIAS_W-1:0] near_alias();
    return ALIAS_W'(32'h20 + $urandom_range(0, 9));
  endfunction

  // Favour a small set of aliases so that adds, removes and checks meet each other
  function automatic logic [ALIAS_W-1:0] pick_alias();
    case ($urandom_range(0, 9))
      0, 1:    return fixed_now[CFG_IDX_W'($urandom_range(0, FIXED_REGS - 1))];
      2:       return UNUSED_CODE;
      3:       return 8'h00;
      4, 5, 6: return near_alias();
      default: return ALIAS_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Stimulus: directed corners, then random phases under different predefined aliases
  initial begin
    int unsigned add_bias;
    int unsigned roll;
    logic [1:0]  op_bits;
    for (int i = 0; i < FIXED_REGS; i++) fixed_now[i] = FIXED_RESET;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    idle_enabled = 1'b1;

    // Empty table: free slots match the unused code
    send_request(OP_CHECK,  8'hFF);
    send_request(OP_CHECK,  8'h00);
    // Fill the table, including an add of the unused code that leaves its slot free
    send_request(OP_ADD,    8'h00);
    send_request(OP_ADD,    8'hFF);
    send_request(OP_ADD,    8'h80);
    send_request(OP_ADD,    8'h01);
    send_request(OP_ADD,    8'h02);
    send_request(OP_ADD,    8'h03);
    send_request(OP_ADD,    8'h04);
    send_request(OP_ADD,    8'h05);
    send_request(OP_ADD,    8'h06);
    // Full table, predefined match, missing removes and an unknown operation
    send_request(OP_ADD,    8'h7F);
    send_request(OP_CHECK,  8'hFF);
    send_request(OP_CHECK,  8'h06);
    send_request(OP_REMOVE, 8'hAA);
    send_request(OP_REMOVE, 8'hFF);
    send_request(OP_UNKNOWN, 8'h55);
    // Free a slot, then remove the unused code from it again
    send_request(OP_REMOVE, 8'h00);
    send_request(OP_REMOVE, 8'hFF);
    send_request(OP_CHECK,  8'h00);
    send_request(OP_UNKNOWN, 8'hAA);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       set_fixed_aliases(8'h00, 8'h01, 8'h7F, 8'hFE);
        1:       set_fixed_aliases(near_alias(), near_alias(), near_alias(), near_alias());
        2:       set_fixed_aliases(8'hFF, 8'h00, 8'hFF, 8'h80);
        default: set_fixed_aliases(ALIAS_W'($urandom_range(0, 255)),
                                   ALIAS_W'($urandom_range(0, 255)),
                                   ALIAS_W'($urandom_range(0, 255)),
                                   ALIAS_W'($urandom_range(0, 255)));
      endcase
      // Back-pressure the result side long enough to fill the block
      if (phase == 0) long_hold_pending = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          add_bias     = $urandom_range(15, 70);
          idle_enabled = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
          op_bits = OP_UNKNOWN;
        else if (roll < 3 + add_bias)
          op_bits = OP_ADD;
        else if (roll % 2 == 0)
          op_bits = OP_REMOVE;
        else
          op_bits = OP_CHECK;
        send_request(op_bits, pick_alias());
      end
      settle();
    end

    if (fail_count == 0 && pending_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
